// ===== rtl/scene_step_sequencer_crossfade_macros.svh =====
// Assertion helpers for the scene step sequencer.
`ifndef SCENE_STEP_SEQUENCER_CROSSFADE_MACROS_SVH
`define SCENE_STEP_SEQUENCER_CROSSFADE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SSC_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's clk and arst_n.
`define SSC_ASSERT(lbl, prop, msg) `SSC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== rtl/ssc_pkg.sv =====
`default_nettype none

package ssc_pkg;

	localparam int MAX_SCENES      = 6;
	localparam int MAX_SCENE_STEPS = 16;
	localparam int LEN_FIELDS      = 6;

	localparam logic [16:0] RAMP_ONE = 17'd65536;
	localparam logic [6:0]  STEP_SAT = 7'd127;
	localparam logic [8:0]  FRAC_ONE = 9'd256;

	localparam logic [2:0] REG_SCENE_COUNT = 3'd0;
	localparam logic [2:0] REG_LOOP_ENABLE = 3'd1;
	localparam logic [2:0] REG_SCENE_LENS  = 3'd2;
	localparam logic [2:0] REG_RAMP_STEP   = 3'd3;
	localparam logic [2:0] REG_FRAC_A      = 3'd4;
	localparam logic [2:0] REG_FRAC_B      = 3'd5;
	localparam logic [2:0] REG_PULSE_TICKS = 3'd6;

	typedef struct packed {
		logic [2:0]  scene_count;
		logic        loop_enable;
		logic [23:0] scene_lengths_minus_one;
		logic [16:0] ramp_step;
		logic [8:0]  alert_fraction_a;
		logic [8:0]  alert_fraction_b;
		logic [15:0] pulse_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  current_scene;
		logic [2:0]  previous_scene;
		logic [16:0] from_gain;
		logic [16:0] to_gain;
		logic        finished;
		logic        alert_a;
		logic        alert_b;
		logic [6:0]  scene_step;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_INIT,
		ST_SCAN,
		ST_WRAP,
		ST_MOD,
		ST_CHG,
		ST_TCHK,
		ST_RAMP,
		ST_OUT
	} ssc_state_t;

	function automatic logic [4:0] scene_len(input logic [23:0] lens, input logic [2:0] idx);
		logic [4:0] len;
		len = 5'd1;
		if (idx < 3'(LEN_FIELDS))
			len = {1'b0, 4'(lens >> {idx, 2'b00})} + 5'd1;
		if (len > 5'(MAX_SCENE_STEPS))
			len = 5'(MAX_SCENE_STEPS);
		return len;
	endfunction

	function automatic logic [5:0] alert_pos(input logic [23:0] lens, input logic [2:0] scene,
		input logic [8:0] frac);
		logic [8:0]  f;
		logic [13:0] p;
		f = (frac > FRAC_ONE) ? FRAC_ONE : frac;
		p = {9'd0, scene_len(lens, scene)} * {5'd0, f};
		return p[13:8];
	endfunction

	function automatic logic [2:0] clamp_scenes(input logic [2:0] cnt);
		logic [2:0] n;
		n = cnt;
		if (n < 3'd1)
			n = 3'd1;
		if (n > 3'(MAX_SCENES))
			n = 3'(MAX_SCENES);
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ssc_alu.sv =====
`default_nettype none

module ssc_alu
	import ssc_pkg::*;
(
	input  wire logic [17:0] a,
	input  wire logic [17:0] b,
	input  wire logic        sub,
	output logic      [17:0] res,
	output logic             cout
);

	logic [18:0] full;

	// sub: cout high means a >= b
	assign full = sub ? ({1'b0, a} + {1'b0, ~b} + 19'd1) : ({1'b0, a} + {1'b0, b});
	assign res  = full[17:0];
	assign cout = full[18];

endmodule

`default_nettype wire

// ===== rtl/ssc_core.sv =====
`default_nettype none

module ssc_core
	import ssc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic in_valid,
	input  wire logic in_trig,
	input  wire logic in_rst,
	output logic      in_ready,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	ssc_state_t state_q, state_d;

	logic        trig_q, rst_q;
	logic [2:0]  last_idx_q;
	logic [2:0]  idx_q;
	logic [2:0]  bit_q;
	logic        k_q;
	logic [6:0]  total_q;
	logic [6:0]  rem_q;

	logic [6:0]  gs_q, ss_q;
	logic [2:0]  now_q, before_q;
	logic [16:0] ramp_q;
	logic        done_q, first_q;
	logic [15:0] timer_q [2];

	logic [17:0] alu_a, alu_b, alu_res;
	logic        alu_sub, alu_cout;
	logic [8:0]  frac_sel;
	logic [5:0]  apos;
	logic        hit;
	logic [2:0]  n_cl;

	ssc_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (alu_sub),
		.res  (alu_res),
		.cout (alu_cout)
	);

	assign n_cl     = clamp_scenes(cfg.scene_count);
	assign frac_sel = k_q ? cfg.alert_fraction_b : cfg.alert_fraction_a;
	assign apos     = alert_pos(cfg.scene_lengths_minus_one, now_q, frac_sel);

	always_comb begin
		alu_a   = 18'd0;
		alu_b   = 18'd0;
		alu_sub = 1'b0;
		case (state_q)
			ST_SCAN: begin
				alu_a = 18'(total_q);
				alu_b = 18'(scene_len(cfg.scene_lengths_minus_one, idx_q));
			end
			ST_MOD: begin
				alu_a   = 18'(rem_q);
				alu_b   = 18'(total_q) << bit_q;
				alu_sub = 1'b1;
			end
			ST_RAMP: begin
				alu_a = 18'(ramp_q);
				alu_b = 18'(cfg.ramp_step);
			end
			default: ;
		endcase
	end

	always_comb begin
		hit = 1'b0;
		case (state_q)
			ST_FIRST: hit = first_q && (apos == 6'd0);
			ST_TCHK:  hit = ({1'b0, apos} == ss_q);
			default:  hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_FIRST;
			end
			ST_FIRST: begin
				if (k_q)
					state_d = trig_q ? ST_INIT : ST_RAMP;
			end
			ST_INIT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (idx_q == last_idx_q)
					state_d = ST_WRAP;
			end
			ST_WRAP: state_d = cfg.loop_enable ? ST_MOD : ST_CHG;
			ST_MOD: begin
				if (bit_q == 3'd0)
					state_d = ST_CHG;
			end
			ST_CHG: state_d = ST_TCHK;
			ST_TCHK: begin
				if (k_q)
					state_d = ST_RAMP;
			end
			ST_RAMP: state_d = ST_OUT;
			ST_OUT: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q     <= 1'b0;
			rst_q      <= 1'b0;
			last_idx_q <= 3'd0;
			idx_q      <= 3'd0;
			bit_q      <= 3'd0;
			k_q        <= 1'b0;
			total_q    <= 7'd0;
			rem_q      <= 7'd0;
			gs_q       <= 7'd0;
			ss_q       <= 7'd0;
			now_q      <= 3'd0;
			before_q   <= 3'd0;
			ramp_q     <= 17'd0;
			done_q     <= 1'b0;
			first_q    <= 1'b1;
			timer_q[0] <= 16'd0;
			timer_q[1] <= 16'd0;
		end else begin
			if ((state_q == ST_FIRST || state_q == ST_TCHK) && hit)
				timer_q[k_q] <= (timer_q[k_q] < cfg.pulse_ticks) ? cfg.pulse_ticks : timer_q[k_q];
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						trig_q     <= in_trig;
						rst_q      <= in_rst;
						last_idx_q <= n_cl - 3'd1;
						k_q        <= 1'b0;
					end
				end
				ST_FIRST: begin
					k_q <= ~k_q;
					if (k_q)
						first_q <= 1'b0;
				end
				ST_INIT: begin
					if (gs_q != STEP_SAT)
						gs_q <= gs_q + 7'd1;
					if (ss_q != STEP_SAT)
						ss_q <= ss_q + 7'd1;
					before_q <= now_q;
					now_q    <= 3'd0;
					total_q  <= 7'd0;
					idx_q    <= 3'd0;
				end
				ST_SCAN: begin
					if (gs_q > total_q)
						now_q <= idx_q;
					total_q <= alu_res[6:0];
					idx_q   <= idx_q + 3'd1;
				end
				ST_WRAP: begin
					if (cfg.loop_enable) begin
						rem_q <= gs_q;
						bit_q <= 3'd6;
					end else if (gs_q >= total_q && !done_q) begin
						done_q <= 1'b1;
						ramp_q <= 17'd0;
					end
				end
				ST_MOD: begin
					if (alu_cout)
						rem_q <= alu_res[6:0];
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0)
						gs_q <= alu_cout ? alu_res[6:0] : rem_q;
				end
				ST_CHG: begin
					if (now_q != before_q) begin
						ss_q   <= 7'd0;
						ramp_q <= 17'd0;
					end
				end
				ST_TCHK: k_q <= ~k_q;
				ST_RAMP: begin
					ramp_q <= (alu_res > 18'(RAMP_ONE)) ? RAMP_ONE : alu_res[16:0];
				end
				ST_OUT: begin
					if (res_ready) begin
						if (timer_q[0] != 16'd0)
							timer_q[0] <= timer_q[0] - 16'd1;
						if (timer_q[1] != 16'd0)
							timer_q[1] <= timer_q[1] - 16'd1;
						if (rst_q) begin
							gs_q   <= 7'd0;
							now_q  <= 3'd0;
							done_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.current_scene  = now_q;
		res.previous_scene = before_q;
		res.from_gain      = 17'(18'(RAMP_ONE) - 18'(ramp_q));
		res.to_gain        = done_q ? 17'd0 : ramp_q;
		res.finished       = done_q;
		res.alert_a        = (timer_q[0] != 16'd0);
		res.alert_b        = (timer_q[1] != 16'd0);
		res.scene_step     = ss_q;
	end

endmodule

`default_nettype wire

// ===== rtl/scene_step_sequencer_crossfade.sv =====
// Scene step sequencer with Q16 crossfade gains, one item per sample tick.
// Without trigger an item runs ST_FIRST, ST_RAMP and ST_OUT before m_tvalid; with
// trigger also ST_INIT, ST_SCAN per scene (count clamped to 1..6), ST_WRAP, ST_MOD
// in loop mode, ST_CHG, ST_TCHK. Input waits for ST_IDLE; one shared add/sub unit.
// Reset (arst_n low): config to defaults, sequencer state cleared, first tick armed.
`default_nettype none

module scene_step_sequencer_crossfade
	import ssc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // trigger, reset_request
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// current_scene, previous_scene, from_gain, to_gain, finished, alert_a,
	// alert_b, scene_step
	output logic      [55:0] m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cfg_t        cfg_q;
	res_t        res;
	logic        res_valid, res_ready;
	logic        wr_en;
	logic [55:0] m_tdata_q;
	logic        m_tvalid_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scene_count             <= 3'd6;
			cfg_q.loop_enable             <= 1'b0;
			cfg_q.scene_lengths_minus_one <= 24'd0;
			cfg_q.ramp_step               <= RAMP_ONE;
			cfg_q.alert_fraction_a        <= FRAC_ONE;
			cfg_q.alert_fraction_b        <= FRAC_ONE;
			cfg_q.pulse_ticks             <= 16'd48;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_SCENE_COUNT: cfg_q.scene_count             <= pwdata[2:0];
				REG_LOOP_ENABLE: cfg_q.loop_enable             <= pwdata[0];
				REG_SCENE_LENS:  cfg_q.scene_lengths_minus_one <= pwdata[23:0];
				REG_RAMP_STEP:   cfg_q.ramp_step               <= pwdata[16:0];
				REG_FRAC_A:      cfg_q.alert_fraction_a        <= pwdata[8:0];
				REG_FRAC_B:      cfg_q.alert_fraction_b        <= pwdata[8:0];
				REG_PULSE_TICKS: cfg_q.pulse_ticks             <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SCENE_COUNT: prdata = 32'(cfg_q.scene_count);
			REG_LOOP_ENABLE: prdata = 32'(cfg_q.loop_enable);
			REG_SCENE_LENS:  prdata = 32'(cfg_q.scene_lengths_minus_one);
			REG_RAMP_STEP:   prdata = 32'(cfg_q.ramp_step);
			REG_FRAC_A:      prdata = 32'(cfg_q.alert_fraction_a);
			REG_FRAC_B:      prdata = 32'(cfg_q.alert_fraction_b);
			REG_PULSE_TICKS: prdata = 32'(cfg_q.pulse_ticks);
			default:         prdata = 32'd0;
		endcase
	end

	ssc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_trig   (s_tdata[0]),
		.in_rst    (s_tdata[1]),
		.in_ready  (s_tready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_ready)
			m_tvalid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			m_tdata_q <= {6'd0, res.scene_step, res.alert_b, res.alert_a, res.finished,
				res.to_gain, res.from_gain, res.previous_scene, res.current_scene};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== rtl/ssc_checker.sv =====
`default_nettype none

`include "scene_step_sequencer_crossfade_macros.svh"

module ssc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata
);

	`SSC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

	`SSC_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "item taken while busy")

	`SSC_ASSERT(a_gain_sum, m_tvalid && !m_tdata[40] |-> ({1'b0, m_tdata[22:6]} + {1'b0, m_tdata[39:23]}) == 18'd65536, "fade gains do not sum to one")

	`SSC_ASSERT(a_finished_mute, m_tvalid && m_tdata[40] |-> m_tdata[39:23] == 17'd0, "to gain nonzero when finished")

	`SSC_ASSERT(a_scene_range, m_tvalid |-> m_tdata[2:0] < 3'd6 && m_tdata[5:3] < 3'd6, "scene index out of range")

endmodule

bind scene_step_sequencer_crossfade ssc_checker u_ssc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
